FILE: design/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants for the timer slot table
// Holds command, result and status codes, payload structs, controller states
// and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int NUM_DIVIDERS = 5;
    localparam int DIV_W        = 7;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ADD_PER = 3'd1,
        CMD_ADD_ONE = 3'd2,
        CMD_KILL    = 3'd3,
        CMD_LATCH   = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_code_t;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_KILL   = 3'd1;
    localparam logic [2:0] KIND_EXPIRY = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_FLAGS  = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADSLOT = 2'd3;

    localparam logic [1:0] MODE_FREE     = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_ONESHOT  = 2'd2;

    function automatic logic [DIV_W-1:0] div_limit(input int i);
        case (i)
            0:       div_limit = 7'd1;
            1:       div_limit = 7'd2;
            2:       div_limit = 7'd5;
            3:       div_limit = 7'd10;
            default: div_limit = 7'd100;
        endcase
    endfunction

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] timeout;
        logic [5:0]  slot;
    } in_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] status;
        logic [5:0] slot_index;
        logic       was_one_shot;
        logic [4:0] tick_flags;
        logic       last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL,
        S_WAIT
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic start_tick; // advance dividers
        logic scan_step;  // process slot at scan index
        logic do_single;  // execute add/kill/latch/clear
        logic emit_hit;   // load held expiry result into output register
        logic emit_final; // load final result into output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic is_valid_cmd;
        logic hit;        // slot at scan index expired this step
        logic scan_done;  // scan index is at the last slot
        logic held;       // an earlier expiry of this tick is held back
    } dp_stat_t;

endpackage

FILE: design/timer_slot_table.sv
// ----------------------------------------------------------------------------
// timer_slot_table: table of periodic and one-shot timer slots
// Top level joining the sequencing controller and the slot datapath.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Add, kill, latch and clear pass
// through capture, execute and loading the result word, which waits on
// out_stall, before the next word is taken. A tick advances the five tick
// dividers, then walks the slot table one slot per cycle while no expiry
// word waits on out_stall, and then loads its final word.
// Each expiry gives one word; it is held back until the next expiry is found
// or the walk ends, so the final one carries last. A tick with no expiry
// gives a single tick-done word. Unknown commands are dropped without a
// result.
module timer_slot_table
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    tst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    tst_dp #(.SLOTS(SLOTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_data),
        .cmd      (dcmd),
        .stat     (dstat),
        .out_word (out_data)
    );

    // the slot walk and a single command never overlap
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(dcmd.scan_step && dcmd.do_single))
        else $error("scan and single command together");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted word did not block the input");

    a_no_double_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(dcmd.emit_hit && dcmd.emit_final))
        else $error("two result loads in one cycle");

endmodule

FILE: design/tst_ctrl.sv
// ----------------------------------------------------------------------------
// tst_ctrl: sequencing controller
// Walks the slot scan for ticks, issues single-step commands otherwise, and
// drives the output register handshake.
// ----------------------------------------------------------------------------
module tst_ctrl
    import tst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    logic out_free;
    assign out_free  = !ovalid_reg || !out_stall;
    assign out_valid = ovalid_reg;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        ovalid_next = ovalid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // decode captured word
                if (!stat.is_valid_cmd)
                    state_next = S_IDLE;
                else if (stat.is_tick)
                begin
                    cmd.start_tick = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.do_single = 1'b1;
                    state_next    = S_FINAL;
                end
            end
            S_SCAN:
            begin
                // a new expiry pushes the held one out; hold the scan until
                // the output register can take it
                if (stat.hit && stat.held)
                begin
                    if (out_free)
                    begin
                        cmd.scan_step = 1'b1;
                        cmd.emit_hit  = 1'b1;
                        ovalid_next   = 1'b1;
                        if (stat.scan_done)
                            state_next = S_FINAL;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_done)
                        state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    cmd.emit_final = 1'b1;
                    ovalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: design/tst_dp.sv
// ----------------------------------------------------------------------------
// tst_dp: slot table datapath
// Holds slot modes, timeouts and counts, the tick dividers and the flags,
// and builds result words.
// ----------------------------------------------------------------------------
module tst_dp
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_word_t out_word
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [1:0]  mode_reg [SLOTS];
    logic [31:0] period_reg [SLOTS];
    logic [31:0] elapsed_reg [SLOTS];
    logic [DIV_W-1:0] div_reg [NUM_DIVIDERS];
    logic [4:0]  pend_reg, vis_reg;
    in_word_t    word_reg;
    logic [IW-1:0] idx_reg;
    logic        any_hit_reg;
    logic [IW-1:0] hold_idx_reg;
    logic        hold_one_reg;
    out_word_t   ow_reg;

    // allocation outcome kept across the single-step
    logic [IW-1:0] alloc_reg;
    logic          found_reg;

    // current slot under scan
    logic        act;
    logic [31:0] inc;
    logic        hit;
    assign act = (mode_reg[idx_reg] == MODE_PERIODIC) || (mode_reg[idx_reg] == MODE_ONESHOT);
    assign inc = (elapsed_reg[idx_reg] != 32'hFFFF_FFFF) ? elapsed_reg[idx_reg] + 32'd1
                                                          : elapsed_reg[idx_reg];
    assign hit = act && (inc >= period_reg[idx_reg]);

    // first free slot search
    logic [IW-1:0] free_idx;
    logic          found;
    always_comb
    begin
        free_idx = '0;
        found    = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mode_reg[i] != MODE_PERIODIC && mode_reg[i] != MODE_ONESHOT)
            begin
                free_idx = IW'(i);
                found    = 1'b1;
            end
        end
    end

    logic kill_ok;
    assign kill_ok = ({1'b0, word_reg.slot} < 7'(SLOTS));

    assign stat.is_tick      = (word_reg.cmd == CMD_TICK);
    assign stat.is_valid_cmd = (word_reg.cmd <= CMD_CLEAR);
    assign stat.hit          = hit;
    assign stat.scan_done    = (idx_reg == IW'(SLOTS - 1));
    assign stat.held         = any_hit_reg;

    // expiry word for the held slot; more expiries follow, so last is clear
    out_word_t hit_word;
    always_comb
    begin
        hit_word.kind         = KIND_EXPIRY;
        hit_word.status       = ST_OK;
        hit_word.slot_index   = 6'(hold_idx_reg);
        hit_word.was_one_shot = hold_one_reg;
        hit_word.tick_flags   = vis_reg;
        hit_word.last         = 1'b0;
    end

    // final word of a command
    out_word_t fin_word;
    always_comb
    begin
        fin_word.kind         = KIND_CLEAR;
        fin_word.status       = ST_OK;
        fin_word.slot_index   = '0;
        fin_word.was_one_shot = 1'b0;
        fin_word.tick_flags   = vis_reg;
        fin_word.last         = 1'b1;
        case (word_reg.cmd)
            CMD_TICK:
            begin
                if (any_hit_reg)
                begin
                    fin_word.kind         = KIND_EXPIRY;
                    fin_word.slot_index   = 6'(hold_idx_reg);
                    fin_word.was_one_shot = hold_one_reg;
                end
                else
                    fin_word.kind = KIND_TICK;
            end
            CMD_ADD_PER, CMD_ADD_ONE:
            begin
                fin_word.kind = KIND_ADD;
                if (word_reg.timeout == 32'd0)
                    fin_word.status = ST_ZERO;
                else if (!found_reg)
                    fin_word.status = ST_FULL;
                else
                    fin_word.slot_index = 6'(alloc_reg);
            end
            CMD_KILL:
            begin
                fin_word.kind       = KIND_KILL;
                fin_word.slot_index = word_reg.slot;
                if (!kill_ok)
                    fin_word.status = ST_BADSLOT;
            end
            CMD_LATCH: fin_word.kind = KIND_FLAGS;
            default:   fin_word.kind = KIND_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                mode_reg[i] <= MODE_FREE;
            for (int d = 0; d < NUM_DIVIDERS; d++)
                div_reg[d] <= '0;
            pend_reg    <= '0;
            vis_reg     <= '0;
            idx_reg     <= '0;
            any_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_tick)
            begin
                for (int d = 0; d < NUM_DIVIDERS; d++)
                begin
                    if (div_reg[d] + 7'd1 >= div_limit(d))
                    begin
                        div_reg[d]  <= '0;
                        pend_reg[d] <= 1'b1;
                    end
                    else
                        div_reg[d] <= div_reg[d] + 7'd1;
                end
                idx_reg     <= '0;
                any_hit_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (hit)
                begin
                    any_hit_reg <= 1'b1;
                    if (mode_reg[idx_reg] == MODE_ONESHOT)
                        mode_reg[idx_reg] <= MODE_FREE;
                end
                if (!stat.scan_done)
                    idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.do_single)
            begin
                case (word_reg.cmd)
                    CMD_ADD_PER, CMD_ADD_ONE:
                        if (word_reg.timeout != 32'd0 && found)
                            mode_reg[free_idx] <= (word_reg.cmd == CMD_ADD_PER)
                                                  ? MODE_PERIODIC : MODE_ONESHOT;
                    CMD_KILL:
                        if (kill_ok)
                            mode_reg[word_reg.slot[IW-1:0]] <= MODE_FREE;
                    CMD_LATCH:
                    begin
                        vis_reg  <= pend_reg;
                        pend_reg <= '0;
                    end
                    CMD_CLEAR: vis_reg <= '0;
                    default: ;
                endcase
            end
        end
    end

    // payload: word capture, slot data, held expiry, result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            word_reg <= in_word;
        if (cmd.scan_step && act)
            elapsed_reg[idx_reg] <= hit ? 32'd0 : inc;
        if (cmd.scan_step && hit)
        begin
            hold_idx_reg <= idx_reg;
            hold_one_reg <= (mode_reg[idx_reg] == MODE_ONESHOT);
        end
        if (cmd.do_single && found && word_reg.timeout != 32'd0 &&
            (word_reg.cmd == CMD_ADD_PER || word_reg.cmd == CMD_ADD_ONE))
        begin
            period_reg[free_idx]  <= word_reg.timeout;
            elapsed_reg[free_idx] <= '0;
        end
        if (cmd.do_single)
        begin
            alloc_reg <= free_idx;
            found_reg <= found;
        end
        if (cmd.emit_hit)
            ow_reg <= hit_word;
        else if (cmd.emit_final)
            ow_reg <= fin_word;
    end

    assign out_word = ow_reg;

endmodule
